// ===== src/vdc_pkg.sv =====
// Shared types and constants for the voxel density classifier.
// Depends on nothing; every other file of the block imports it.
package vdc_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Fixed field widths
	localparam int SIZE_W  = 11;
	localparam int EDGE_W  = 16;
	localparam int REST_W  = 20;
	localparam int RECIP_W = 32;
	localparam int POS_W   = 26;
	localparam int OPA_W   = 16;
	localparam int COL_W   = 8;

	// Register reset values
	localparam logic [SIZE_W-1:0]  SIZE_RST  = 11'd1;
	localparam logic [EDGE_W-1:0]  EDGE_RST  = 16'd4096;
	localparam logic [REST_W-1:0]  REST_RST  = 20'd64000;
	localparam logic [RECIP_W-1:0] RECIP_RST = 32'd16777216;

	// Q0.16 constants, one integer bit of headroom for 1.0
	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [16:0] HALF_Q16 = 17'd32768;
	localparam logic [OPA_W-1:0] OPACITY_BASE = 16'd1638;
	localparam logic [OPA_W-1:0] OPACITY_MIN  = 16'd3276;
	localparam logic [COL_W-1:0] GREY_8       = 8'd204;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_X,
		REG_GRID_Y,
		REG_GRID_Z,
		REG_STRIDE,
		REG_EDGE,
		REG_REST,
		REG_RECIP,
		REG_MODE
	} vdc_reg_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SYNC,
		ST_MUL,
		ST_NORM,
		ST_SQ,
		ST_OUT
	} vdc_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic mul_d;
		logic norm;
		logic square;
		logic emit;
		logic rs_start;
		logic rs_step;
	} vdc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic stride_wr;
		logic on_lattice;
		logic out_busy;
	} vdc_status_t;

endpackage

// ===== src/vdc_if.sv =====
// Valid/ready channel interfaces for density samples and voxel results.
// Depends on vdc_pkg for the result field widths.
interface vdc_sample_if #(
	parameter int DENSITY_BITS = 20
) ();
	logic                    valid;
	logic                    ready;
	logic [DENSITY_BITS-1:0] density;

	modport source (output valid, output density, input ready);
	modport sink (input valid, input density, output ready);
endinterface

interface vdc_voxel_if import vdc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] center_x;
	logic [POS_W-1:0] center_y;
	logic [POS_W-1:0] center_z;
	logic [OPA_W-1:0] opacity;
	logic [COL_W-1:0] red;
	logic [COL_W-1:0] green;
	logic [COL_W-1:0] blue;

	modport source (output valid, output center_x, output center_y, output center_z,
		output opacity, output red, output green, output blue, input ready);
	modport sink (input valid, input center_x, input center_y, input center_z,
		input opacity, input red, input green, input blue, output ready);
endinterface

// ===== src/voxel_density_classifier.sv =====
// Top level of the voxel density classifier.
// Depends on vdc_pkg, vdc_if, vdc_ctrl and vdc_dp.
//
// Usage: density samples arrive on the sample channel in raster order, x
// fastest, then y, then z; the block counts the cell position itself. Kept
// voxels leave on the voxel channel as centre, opacity and RGB colour. The
// user must write registers through cfg_we/cfg_index/cfg_data while idle;
// the block itself does not enforce this.
// Timing: a sample off the stride lattice is done in its accept cycle, so
// such samples stream at one per cycle while no stride write or phase
// rebuild holds them. A sample on the lattice is accepted and then passes
// four controller steps (multiply, ratio, square, result); the multiply
// and ratio steps share the pair of 16-bit reciprocal multipliers. Its
// result is registered in the result step, or is dropped for low opacity.
// A stride register write blocks samples in its own cycle and starts a
// phase rebuild during which no sample is taken.
// Reset clears the cell counters to the grid origin, restores register
// defaults and empties the result register. A stalled receiver holds the
// result register; the next sample is still taken and processed, and waits
// in its final step until the held result is taken.
module voxel_density_classifier import vdc_pkg::*; #(
	parameter int GRID_MAX     = 1024,
	parameter int DENSITY_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vdc_sample_if.sink            sample,
	vdc_voxel_if.source           voxel
);

	vdc_cmd_t    cmd;
	vdc_status_t st;

	// sequence each sample through the datapath
	vdc_ctrl #(
		.GRID_MAX (GRID_MAX)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.st           (st),
		.cmd          (cmd)
	);

	// counters, arithmetic and result register
	vdc_dp #(
		.GRID_MAX     (GRID_MAX),
		.DENSITY_BITS (DENSITY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.density   (sample.density),
		.cmd       (cmd),
		.st        (st),
		.voxel     (voxel)
	);

endmodule

// ===== src/vdc_ctrl.sv =====
// Controller state machine of the voxel density classifier.
// Depends on vdc_pkg for the state, command and status types.
module vdc_ctrl import vdc_pkg::*; #(
	parameter int GRID_MAX = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  vdc_status_t st,
	output vdc_cmd_t    cmd
);

	localparam int CNTW = $clog2(GRID_MAX);
	localparam int STW  = $clog2(CNTW + 1);
	localparam logic [STW-1:0] LAST_STEP = STW'(CNTW - 1);

	vdc_state_t     state_q, state_nx;
	logic [STW-1:0] step_q;
	logic           pend_q;
	logic           accept;

	// take a beat only when idle and the lattice phases are current
	assign sample_ready = (state_q == ST_IDLE) && !pend_q && !st.stride_wr;
	assign accept       = sample_valid && sample_ready;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pend_q || st.stride_wr) state_nx = ST_SYNC;
				else if (accept && st.on_lattice) state_nx = ST_MUL;
			end
			ST_SYNC: begin
				if (!st.stride_wr && step_q == LAST_STEP) state_nx = ST_IDLE;
			end
			ST_MUL:  state_nx = ST_NORM;
			ST_NORM: state_nx = ST_SQ;
			ST_SQ:   state_nx = ST_OUT;
			ST_OUT: begin
				if (!st.out_busy) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		case (state_q)
			ST_IDLE: cmd.rs_start = pend_q || st.stride_wr;
			ST_SYNC: begin
				cmd.rs_start = st.stride_wr;
				cmd.rs_step  = !st.stride_wr;
			end
			ST_MUL:  cmd.mul_d  = 1'b1;
			ST_NORM: cmd.norm   = 1'b1;
			ST_SQ:   cmd.square = 1'b1;
			ST_OUT:  cmd.emit   = !st.out_busy;
			default: ;
		endcase
	end

	// state, resync step count and pending stride change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.rs_start) step_q <= '0;
			else if (cmd.rs_step) step_q <= step_q + STW'(1);
			if (cmd.rs_start) pend_q <= 1'b0;
			else if (st.stride_wr) pend_q <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_after_stride: assert property (@(posedge clk) disable iff (!arst_n)
		st.stride_wr |=> !cmd.accept)
		else $error("sample taken right after a stride write");
`endif

endmodule

// ===== src/vdc_dp.sv =====
// Datapath of the voxel density classifier: configuration registers, cell
// counters, lattice phases, ratio and colour arithmetic, result register.
// Depends on vdc_pkg and the vdc_voxel_if interface.
module vdc_dp import vdc_pkg::*; #(
	parameter int GRID_MAX     = 1024,
	parameter int DENSITY_BITS = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic [DENSITY_BITS-1:0] density,
	input  vdc_cmd_t                cmd,
	output vdc_status_t             st,
	vdc_voxel_if.source             voxel
);

	localparam int CNTW  = $clog2(GRID_MAX);
	localparam int SZW   = ($clog2(GRID_MAX) + 1 > SIZE_W) ? $clog2(GRID_MAX) + 1 : SIZE_W;
	localparam int DEV_W = (DENSITY_BITS > REST_W) ? DENSITY_BITS : REST_W;
	localparam int PRW   = DEV_W + 16;
	localparam int SUMW  = DEV_W + 33;
	localparam int CPW   = (CNTW + 17 > POS_W + 1) ? CNTW + 17 : POS_W + 1;

	// configuration
	logic [SIZE_W-1:0]  size_q [3];
	logic [SIZE_W-1:0]  stride_q;
	logic [EDGE_W-1:0]  edge_q;
	logic [REST_W-1:0]  rest_q;
	logic [RECIP_W-1:0] recip_q;
	logic               mode_q;

	// position state
	logic [CNTW-1:0] cell_q  [3];
	logic [CNTW-1:0] phase_q [3];
	logic [CNTW-1:0] shift_q [3];
	logic [CNTW-1:0] cell_nx [3];
	logic [CNTW-1:0] phase_nx [3];
	logic [CNTW-1:0] phase_rs [3];
	logic [2:0]      adv, wrap;
	logic [SZW-1:0]  stride_eff;

	// item registers
	logic [DENSITY_BITS-1:0] d_q;
	logic [CNTW-1:0]         pos_q [3];
	logic [CNTW+16:0]        cprod_q [3];
	logic [DEV_W-1:0]        dev_q;
	logic                    above_q;
	logic [PRW-1:0]          prod_lo_q, prod_hi_q;
	logic [16:0]             norm_q, r_q, sq_q;

	// result register
	logic             out_valid_q;
	logic [POS_W-1:0] cx_q, cy_q, cz_q;
	logic [OPA_W-1:0] opa_q;
	logic [COL_W-1:0] red_q, green_q, blue_q;

	// combinational
	logic [DEV_W-1:0] d_ext, rest_ext, mul_op;
	logic [33:0]      sq_full;
	logic [17:0]      sq3;
	logic [OPA_W-1:0] opa;
	logic             keep, low;
	logic [17:0]      r2;
	logic [16:0]      t, cr, cg, cb;
	logic [COL_W-1:0] r8, g8, b8;
	logic [CPW-1:0]   cw [3];

	function automatic logic [SZW-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SZW-1:0] w;
		w = SZW'(v);
		if (w == '0) return SZW'(1);
		if (w > SZW'(GRID_MAX)) return SZW'(GRID_MAX);
		return w;
	endfunction

	function automatic logic [CNTW-1:0] rem_step(input logic [CNTW-1:0] ph, input logic b,
		input logic [SZW-1:0] s);
		logic [SZW-1:0] w;
		w = SZW'({ph, b});
		if (w >= s) w = w - s;
		return w[CNTW-1:0];
	endfunction

	function automatic logic [16:0] ratio(input logic [PRW-1:0] lo, input logic [PRW-1:0] hi);
		logic [SUMW-1:0] s;
		s = SUMW'({hi, 16'b0}) + SUMW'(lo);
		if (s[SUMW-1:14] > (SUMW-14)'(ONE_Q16)) return ONE_Q16;
		return s[30:14];
	endfunction

	function automatic logic [COL_W-1:0] to8(input logic [16:0] c);
		logic [25:0] p;
		p = 26'({c, 8'b0}) - 26'(c) + 26'(HALF_Q16);
		return p[23:16];
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q[0] <= SIZE_RST;
			size_q[1] <= SIZE_RST;
			size_q[2] <= SIZE_RST;
			stride_q  <= SIZE_RST;
			edge_q    <= EDGE_RST;
			rest_q    <= REST_RST;
			recip_q   <= RECIP_RST;
			mode_q    <= 1'b0;
		end else if (cfg_we) begin
			case (vdc_reg_t'(cfg_index))
				REG_GRID_X: size_q[0] <= cfg_data[SIZE_W-1:0];
				REG_GRID_Y: size_q[1] <= cfg_data[SIZE_W-1:0];
				REG_GRID_Z: size_q[2] <= cfg_data[SIZE_W-1:0];
				REG_STRIDE: stride_q  <= cfg_data[SIZE_W-1:0];
				REG_EDGE:   edge_q    <= cfg_data[EDGE_W-1:0];
				REG_REST:   rest_q    <= cfg_data[REST_W-1:0];
				REG_RECIP:  recip_q   <= cfg_data[RECIP_W-1:0];
				REG_MODE:   mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign stride_eff = (stride_q == '0) ? SZW'(1) : SZW'(stride_q);

	// advance the raster counters and their phases against the stride
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wrap[i] = (SZW'(cell_q[i]) + SZW'(1)) >= clamp_size(size_q[i]);
		end
		adv[0] = 1'b1;
		adv[1] = wrap[0];
		adv[2] = wrap[0] && wrap[1];
		for (int i = 0; i < 3; i++) begin
			if (!adv[i]) begin
				cell_nx[i]  = cell_q[i];
				phase_nx[i] = phase_q[i];
			end else if (wrap[i]) begin
				cell_nx[i]  = '0;
				phase_nx[i] = '0;
			end else begin
				cell_nx[i]  = cell_q[i] + CNTW'(1);
				phase_nx[i] = ((SZW'(phase_q[i]) + SZW'(1)) >= stride_eff) ? '0
					: phase_q[i] + CNTW'(1);
			end
			phase_rs[i] = rem_step(phase_q[i], shift_q[i][CNTW-1], stride_eff);
		end
	end

	// hold counters; rebuild phases bit by bit after a stride change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				cell_q[i]  <= '0;
				phase_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (cmd.accept) begin
					cell_q[i]  <= cell_nx[i];
					phase_q[i] <= phase_nx[i];
				end else if (cmd.rs_start) begin
					phase_q[i] <= '0;
				end else if (cmd.rs_step) begin
					phase_q[i] <= phase_rs[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (cmd.rs_start) shift_q[i] <= cell_q[i];
			else if (cmd.rs_step) shift_q[i] <= shift_q[i] << 1;
		end
	end

	assign st.stride_wr  = cfg_we && (vdc_reg_t'(cfg_index) == REG_STRIDE);
	assign st.on_lattice = (phase_q[0] == '0) && (phase_q[1] == '0) && (phase_q[2] == '0);
	assign st.out_busy   = out_valid_q && !voxel.ready;

	// deviation from the resting density and the shared ratio multipliers
	assign d_ext    = DEV_W'(d_q);
	assign rest_ext = DEV_W'(rest_q);
	assign mul_op   = cmd.norm ? dev_q : d_ext;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			d_q <= density;
			for (int i = 0; i < 3; i++) pos_q[i] <= cell_q[i];
		end
		if (cmd.mul_d) begin
			above_q <= d_ext >= rest_ext;
			dev_q   <= (d_ext >= rest_ext) ? d_ext - rest_ext : rest_ext - d_ext;
			for (int i = 0; i < 3; i++)
				cprod_q[i] <= (CNTW+17)'({pos_q[i], 1'b1}) * (CNTW+17)'(edge_q);
		end
		if (cmd.mul_d || cmd.norm) begin
			prod_lo_q <= PRW'(mul_op) * PRW'(recip_q[15:0]);
			prod_hi_q <= PRW'(mul_op) * PRW'(recip_q[31:16]);
		end
		if (cmd.norm) norm_q <= ratio(prod_lo_q, prod_hi_q);
		if (cmd.square) begin
			sq_q <= sq_full[32:16];
			r_q  <= ratio(prod_lo_q, prod_hi_q);
		end
	end

	assign sq_full = 34'(norm_q) * 34'(norm_q);

	// opacity and keep test
	assign sq3  = {sq_q, 1'b0} + 18'(sq_q);
	assign opa  = OPACITY_BASE + OPA_W'(sq3[17:3]);
	assign keep = opa > OPACITY_MIN;

	// colour ramps on the relative deviation
	always_comb begin
		low = r_q < HALF_Q16;
		r2  = {r_q, 1'b0};
		t   = low ? r2[16:0] : 17'(r2 - 18'(ONE_Q16));
		if (above_q) begin
			cr = low ? t : ONE_Q16;
			cg = low ? ONE_Q16 : ONE_Q16 - t;
			cb = '0;
		end else begin
			cr = low ? (t >> 1) : HALF_Q16 + (t >> 1);
			cg = ONE_Q16;
			cb = cr;
		end
		r8 = mode_q ? to8(cr) : GREY_8;
		g8 = mode_q ? to8(cg) : GREY_8;
		b8 = mode_q ? to8(cb) : GREY_8;
		for (int i = 0; i < 3; i++) cw[i] = CPW'(cprod_q[i]);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit && keep) out_valid_q <= 1'b1;
		else if (voxel.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && keep) begin
			cx_q    <= cw[0][POS_W:1];
			cy_q    <= cw[1][POS_W:1];
			cz_q    <= cw[2][POS_W:1];
			opa_q   <= opa;
			red_q   <= r8;
			green_q <= g8;
			blue_q  <= b8;
		end
	end

	assign voxel.valid    = out_valid_q;
	assign voxel.center_x = cx_q;
	assign voxel.center_y = cy_q;
	assign voxel.center_z = cz_q;
	assign voxel.opacity  = opa_q;
	assign voxel.red      = red_q;
	assign voxel.green    = green_q;
	assign voxel.blue     = blue_q;

`ifndef SYNTHESIS
	a_phase_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q[0] <= cell_q[0]) && (phase_q[1] <= cell_q[1]) && (phase_q[2] <= cell_q[2]))
		else $error("lattice phase ran ahead of its cell counter");
	a_opacity_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (opa_q > OPACITY_MIN))
		else $error("result held with opacity at or below the threshold");
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.accept, 5))
		else $error("result appeared without a sample five cycles earlier");
`endif

endmodule

// ===== tb/voxel_density_classifier_tb.sv =====
// Testbench for voxel_density_classifier: streams density samples and checks
// every voxel beat against a raster-walking classifier kept alongside.
// Depends on vdc_pkg, vdc_if and the block's RTL.
module voxel_density_classifier_tb import vdc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_MAX     = 1024;
	localparam int DENSITY_BITS = 20;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic [SIZE_W-1:0]  size_x;
		logic [SIZE_W-1:0]  size_y;
		logic [SIZE_W-1:0]  size_z;
		logic [SIZE_W-1:0]  stride;
		logic [EDGE_W-1:0]  edge_len;
		logic [REST_W-1:0]  rest;
		logic [RECIP_W-1:0] recip;
		logic               mode;
	} grid_cfg_t;

	typedef struct {
		logic [POS_W-1:0] cx;
		logic [POS_W-1:0] cy;
		logic [POS_W-1:0] cz;
		logic [OPA_W-1:0] opa;
		logic [COL_W-1:0] r;
		logic [COL_W-1:0] g;
		logic [COL_W-1:0] b;
	} voxel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vdc_sample_if #(.DENSITY_BITS(DENSITY_BITS)) sample_ch ();
	vdc_voxel_if voxel_ch ();

	voxel_density_classifier #(
		.GRID_MAX    (GRID_MAX),
		.DENSITY_BITS(DENSITY_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample_ch),
		.voxel    (voxel_ch)
	);

	// Register copy and raster position of the classifier
	logic [SIZE_W-1:0]  reg_size_x, reg_size_y, reg_size_z, reg_stride;
	logic [EDGE_W-1:0]  reg_edge;
	logic [REST_W-1:0]  reg_rest;
	logic [RECIP_W-1:0] reg_recip;
	logic               reg_mode;
	int unsigned        cell_x, cell_y, cell_z;

	voxel_t pending_voxels[$];
	bit     steady_flow;
	int     samples_sent, voxels_checked, ramp_voxels, settings_applied, mismatches;
	int     idle_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v);
		if (v == 0) return 1;
		if (v > GRID_MAX) return GRID_MAX;
		return v;
	endfunction

	// Q6 quantity times the reciprocal, back to Q0.16, saturated at one
	function automatic int unsigned ratio_q16(input longint unsigned num);
		longint unsigned p;
		p = (num * reg_recip) >> 14;
		return (p > 65536) ? 65536 : int'(p);
	endfunction

	function automatic logic [COL_W-1:0] to_8bit(input int unsigned c);
		longint unsigned s;
		s = (longint'(c) * 255 + 32768) >> 16;
		return s[COL_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] cell_centre(input int unsigned idx);
		longint unsigned w;
		w = ((longint'(idx) * 2 + 1) * reg_edge) >> 1;
		return w[POS_W-1:0];
	endfunction

	function automatic void apply_reg(input vdc_reg_t idx, input logic [CFG_DATA_W-1:0] v);
		case (idx)
			REG_GRID_X: reg_size_x = v[SIZE_W-1:0];
			REG_GRID_Y: reg_size_y = v[SIZE_W-1:0];
			REG_GRID_Z: reg_size_z = v[SIZE_W-1:0];
			REG_STRIDE: reg_stride = v[SIZE_W-1:0];
			REG_EDGE:   reg_edge   = v[EDGE_W-1:0];
			REG_REST:   reg_rest   = v[REST_W-1:0];
			REG_RECIP:  reg_recip  = v[RECIP_W-1:0];
			REG_MODE:   reg_mode   = v[0];
			default: ;
		endcase
	endfunction

	// Classify one accepted sample and queue the voxel it yields, if any
	function automatic void classify_sample(input logic [DENSITY_BITS-1:0] d);
		int unsigned step, x, y, z, norm, sq, opa, dev, r, t, cr, cg, cb;
		logic above, low;
		voxel_t v;
		step = (reg_stride == 0) ? 1 : reg_stride;
		x = cell_x;
		y = cell_y;
		z = cell_z;
		// advance the raster position, x fastest
		if (cell_x + 1 >= clamp_size(reg_size_x)) begin
			cell_x = 0;
			if (cell_y + 1 >= clamp_size(reg_size_y)) begin
				cell_y = 0;
				if (cell_z + 1 >= clamp_size(reg_size_z)) cell_z = 0;
				else cell_z = cell_z + 1;
			end else begin
				cell_y = cell_y + 1;
			end
		end else begin
			cell_x = cell_x + 1;
		end
		// skip samples off the lattice
		if ((x % step) != 0 || (y % step) != 0 || (z % step) != 0) return;
		norm = ratio_q16(d);
		sq   = 32'((longint'(norm) * norm) >> 16);
		opa  = OPACITY_BASE + ((3 * sq) >> 3);
		// drop nearly transparent voxels
		if (opa <= OPACITY_MIN) return;
		if (reg_mode) begin
			above = (d >= reg_rest);
			dev   = above ? (d - reg_rest) : (reg_rest - d);
			r     = ratio_q16(dev);
			low   = (r < 32768);
			t     = low ? 2 * r : 2 * r - 65536;
			if (above) begin
				cr = low ? t : 65536;
				cg = low ? 65536 : 65536 - t;
				cb = 0;
			end else begin
				cr = low ? (t >> 1) : 32768 + (t >> 1);
				cg = 65536;
				cb = cr;
			end
			v.r = to_8bit(cr);
			v.g = to_8bit(cg);
			v.b = to_8bit(cb);
			ramp_voxels++;
		end else begin
			v.r = GREY_8;
			v.g = GREY_8;
			v.b = GREY_8;
		end
		v.cx  = cell_centre(x);
		v.cy  = cell_centre(y);
		v.cz  = cell_centre(z);
		v.opa = opa[OPA_W-1:0];
		pending_voxels = {pending_voxels, v};
	endfunction

	// Fill the unused upper bits of a register write with noise
	function automatic logic [CFG_DATA_W-1:0] with_stray_bits(input logic [CFG_DATA_W-1:0] v,
			input int w);
		logic [CFG_DATA_W-1:0] junk;
		junk = $urandom();
		return (w >= CFG_DATA_W) ? v : ((junk << w) | v);
	endfunction

	function automatic grid_cfg_t make_cfg(input int sx, input int sy, input int sz,
			input int stride, input int edge_len, input int rest, input logic [31:0] recip,
			input logic mode);
		grid_cfg_t c;
		c.size_x   = SIZE_W'(sx);
		c.size_y   = SIZE_W'(sy);
		c.size_z   = SIZE_W'(sz);
		c.stride   = SIZE_W'(stride);
		c.edge_len = EDGE_W'(edge_len);
		c.rest     = REST_W'(rest);
		c.recip    = recip;
		c.mode     = mode;
		return c;
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return SIZE_W'(GRID_MAX);
			2: return 11'h7FF;
			default: return SIZE_W'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic grid_cfg_t random_cfg();
		grid_cfg_t c;
		c.size_x = pick_size();
		c.size_y = pick_size();
		c.size_z = pick_size();
		case ($urandom_range(0, 7))
			0: c.stride = 0;
			1: c.stride = SIZE_W'(GRID_MAX);
			2: c.stride = 11'h7FF;
			3: c.stride = SIZE_W'($urandom_range(0, 11'h7FF));
			default: c.stride = SIZE_W'($urandom_range(1, 3));
		endcase
		case ($urandom_range(0, 3))
			0: c.edge_len = 0;
			1: c.edge_len = 16'hFFFF;
			default: c.edge_len = EDGE_W'($urandom_range(0, 16'hFFFF));
		endcase
		case ($urandom_range(0, 5))
			0: c.rest = 0;
			1: c.rest = 20'hFFFFF;
			default: c.rest = REST_W'($urandom_range(64, 400000));
		endcase
		case ($urandom_range(0, 4))
			0: c.recip = 0;
			1: c.recip = 32'hFFFF_FFFF;
			2: c.recip = $urandom();
			default: c.recip = (c.rest == 0) ? RECIP_RST : (32'd1 << 30) / c.rest;
		endcase
		c.mode = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Densities spread over the whole range, near zero and around the rest level
	function automatic logic [DENSITY_BITS-1:0] pick_density();
		longint unsigned v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 20'hFFFFF);
			1: v = (longint'(reg_rest) * $urandom_range(0, 300)) / 100;
			2: v = $urandom_range(0, 255);
			default: begin
				v = longint'(reg_rest) + $urandom_range(0, 128);
				v = (v < 64) ? 0 : v - 64;
			end
		endcase
		if (v > 20'hFFFFF) v = 20'hFFFFF;
		return v[DENSITY_BITS-1:0];
	endfunction

	task automatic write_reg(input vdc_reg_t idx, input logic [CFG_DATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		apply_reg(idx, v);
	endtask

	// Write every register; stride goes last as it starts the phase rebuild
	task automatic configure(input grid_cfg_t c);
		write_reg(REG_GRID_X, with_stray_bits(c.size_x, SIZE_W));
		write_reg(REG_GRID_Y, with_stray_bits(c.size_y, SIZE_W));
		write_reg(REG_GRID_Z, with_stray_bits(c.size_z, SIZE_W));
		write_reg(REG_EDGE, with_stray_bits(c.edge_len, EDGE_W));
		write_reg(REG_REST, with_stray_bits(c.rest, REST_W));
		write_reg(REG_RECIP, c.recip);
		write_reg(REG_MODE, with_stray_bits(c.mode, 1));
		write_reg(REG_STRIDE, with_stray_bits(c.stride, SIZE_W));
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// Send one density beat after a random gap, none in steady flow
	task automatic send_sample(input logic [DENSITY_BITS-1:0] d);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.density <= d;
		do @(posedge clk); while (!sample_ch.ready);
		classify_sample(d);
		samples_sent++;
	endtask

	// Hold the sender until every queued voxel has been taken
	task automatic drain_voxels();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_voxels.size() != 0);
	endtask

	// Drain, then give a dropped sample in flight time to finish
	task automatic settle();
		drain_voxels();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Defaults after reset: opacity threshold either side, saturated density
	task automatic test_reset_defaults();
		send_sample(0);
		send_sample(16);
		send_sample(17);
		send_sample(20'hFFFFF);
	endtask

	// Both ramps, both halves of each, saturated deviation
	task automatic test_colour_ramps();
		settle();
		configure(make_cfg(1, 1, 1, 1, EDGE_RST, 64000, 16777, 1'b1));
		send_sample(64000);
		send_sample(80000);
		send_sample(112000);
		send_sample(192000);
		send_sample(48000);
		send_sample(38400);
		send_sample(25600);
		send_sample(20'hFFFFF);
	endtask

	// Zero rest density with zero and with full-scale reciprocal
	task automatic test_zero_rest();
		settle();
		configure(make_cfg(1, 1, 1, 1, EDGE_RST, 0, 32'd0, 1'b1));
		send_sample(500);
		settle();
		configure(make_cfg(1, 1, 1, 1, EDGE_RST, 0, 32'hFFFF_FFFF, 1'b1));
		send_sample(0);
		send_sample(1);
	endtask

	// Walk a small grid past the end of the frame: zero z size, zero stride,
	// widest cell edge
	task automatic test_raster_walk();
		settle();
		configure(make_cfg(3, 2, 0, 0, 16'hFFFF, 64000, 16777, 1'b0));
		repeat (8) send_sample(DENSITY_BITS'(20'hFFFFF - $urandom_range(0, 1000)));
	endtask

	// Random settings in turn; counters carry over so grids shrink mid-frame
	task automatic test_random_phases();
		for (int p = 0; p < 15; p++) begin
			settle();
			configure(random_cfg());
			steady_flow = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 40; i++) begin
				send_sample(pick_density());
				if (p == 7 && i == 20) drain_voxels();
			end
		end
		steady_flow = 1'b0;
	endtask

	// Stimulus
	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_GRID_X;
		cfg_data          <= '0;
		sample_ch.valid   <= 1'b0;
		sample_ch.density <= '0;
		steady_flow       = 1'b0;
		samples_sent      = 0;
		ramp_voxels       = 0;
		settings_applied  = 0;
		reg_size_x = SIZE_RST;
		reg_size_y = SIZE_RST;
		reg_size_z = SIZE_RST;
		reg_stride = SIZE_RST;
		reg_edge   = EDGE_RST;
		reg_rest   = REST_RST;
		reg_recip  = RECIP_RST;
		reg_mode   = 1'b0;
		cell_x = 0;
		cell_y = 0;
		cell_z = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_colour_ramps();
		test_zero_rest();
		test_raster_walk();
		test_random_phases();
		settle();

		$display("Sent %0d density samples over %0d register settings.",
			samples_sent, settings_applied);
		$display("Checked %0d voxels, %0d of them on the deviation ramp.",
			voxels_checked, ramp_voxels);
		if (mismatches == 0 && pending_voxels.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Take voxel beats after random stalls, none in steady flow, and check them in order
	initial begin
		int stall;
		voxel_t want;
		voxels_checked = 0;
		mismatches     = 0;
		voxel_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				voxel_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			voxel_ch.ready <= 1'b1;
			do @(posedge clk); while (voxel_ch.valid !== 1'b1);
			if (pending_voxels.size() == 0) begin
				$error("voxel beat with none expected: centre %0d,%0d,%0d",
					voxel_ch.center_x, voxel_ch.center_y, voxel_ch.center_z);
				mismatches++;
			end else begin
				want = pending_voxels.pop_front();
				compare_field("center_x", want.cx, voxel_ch.center_x);
				compare_field("center_y", want.cy, voxel_ch.center_y);
				compare_field("center_z", want.cz, voxel_ch.center_z);
				compare_field("opacity", want.opa, voxel_ch.opacity);
				compare_field("red", want.r, voxel_ch.red);
				compare_field("green", want.g, voxel_ch.green);
				compare_field("blue", want.b, voxel_ch.blue);
				voxels_checked++;
			end
		end
	end

	// Watchdog: count cycles without a beat on either channel
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (voxel_ch.valid && voxel_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timed out after %0d cycles without a beat.", idle_cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule
